[src/ita_pkg.sv]
// Shared types and constants for the indexed triangle area block.
// The front queue, the back sequencer and the square root unit use it.
// Depends on nothing.
package ita_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int IDX_W        = $clog2(VERTEX_COUNT);
  localparam int COORD_W      = 16;
  localparam int VTX_W        = 3 * COORD_W;
  localparam int EDGE_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * EDGE_W;
  localparam int MAG_W        = 36;
  localparam int HALF_W       = MAG_W / 2;
  localparam int SUM_W        = 2 * MAG_W;
  localparam int ROOT_W       = 36;
  localparam int AREA_W       = 35;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef struct packed {
    action_t                    action;
    logic [IDX_W-1:0]           addr;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic [IDX_W-1:0]           b;
    logic [IDX_W-1:0]           c;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_res_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RDB,
    B_RDC,
    B_CAPC,
    B_EDGE,
    B_MUL,
    B_DIFF,
    B_SQ,
    B_ROOT,
    B_DONE
  } back_state_t;

endpackage

[src/ita_front.sv]
// Front end: accepts input beats, classifies them into commands, queues them.
// Depends on ita_pkg.
module ita_front import ita_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [IDX_W-1:0]          vertex_index,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic [IDX_W-1:0]          corner_a,
  input  logic [IDX_W-1:0]          corner_b,
  input  logic [IDX_W-1:0]          corner_c,
  input  logic                      pop,
  output cmd_t                      head,
  output q_stat_t                   stat
);

  cmd_t              q [QDEPTH];
  cmd_t              cmd_in;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop_ok;

  always_comb begin
    cmd_in.action = action_t'(action);
    cmd_in.addr   = (action == ACT_QUERY) ? corner_a : vertex_index;
    cmd_in.x      = coord_x;
    cmd_in.y      = coord_y;
    cmd_in.z      = coord_z;
    cmd_in.b      = corner_b;
    cmd_in.c      = corner_c;
  end

  assign in_stall = (count == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign pop_ok   = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop_ok) rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCNT_W'(push) - QCNT_W'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cmd_in;
  end

  assign head       = q[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.count = count;

endmodule

[src/ita_isqrt.sv]
// Bit-serial integer square root, one root bit per cycle.
// Depends on ita_pkg.
module ita_isqrt import ita_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] s,
  output sqrt_res_t        res
);

  localparam int REM_W = ROOT_W + 4;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [SUM_W-1:0]  sreg;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [ROOT_W-1:0] root;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  assign rem_sh = {rem[REM_W-3:0], sreg[SUM_W-1 -: 2]};
  assign trial  = {(REM_W-ROOT_W-2)'(0), root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sreg <= s;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      sreg <= {sreg[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign res.done = done;
  assign res.root = root;

endmodule

[src/ita_back.sv]
// Back end: vertex memory, corner reads, cross product, sum of squares, area out.
// Depends on ita_pkg and ita_isqrt.
module ita_back import ita_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              head,
  input  q_stat_t           qs,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [AREA_W-1:0] tri_area
);

  back_state_t              state, state_next;
  logic [VTX_W-1:0]         mem [VERTEX_COUNT];
  logic [VTX_W-1:0]         rd_data;
  logic [IDX_W-1:0]         raddr;
  logic                     we;
  logic [IDX_W-1:0]         qb, qc;
  logic [VTX_W-1:0]         va, vb, vc;
  logic signed [EDGE_W-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [EDGE_W-1:0] m1a, m1b, m2a, m2b;
  logic signed [PROD_W-1:0] p1, p2;
  logic signed [PROD_W:0]   d;
  logic [MAG_W-1:0]         wmag;
  logic [HALF_W-1:0]        op_a, op_b;
  logic [MAG_W-1:0]         pp;
  logic [SUM_W-1:0]         pp_sh;
  logic [SUM_W-1:0]         acc;
  logic [1:0]               k, j;
  logic                     sq_start;
  logic                     out_load;
  sqrt_res_t                sq;

  ita_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .s     (acc + pp_sh),
    .res   (sq)
  );

  always_ff @(posedge clk) begin
    if (we) mem[head.addr] <= {head.x, head.y, head.z};
    rd_data <= mem[raddr];
  end

  always_comb begin
    case (k)
      2'd0: begin m1a = uy; m1b = vz; m2a = uz; m2b = vy; end
      2'd1: begin m1a = uz; m1b = vx; m2a = ux; m2b = vz; end
      default: begin m1a = ux; m1b = vy; m2a = uy; m2b = vx; end
    endcase
    d = (PROD_W+1)'(p1) - (PROD_W+1)'(p2);
    case (j)
      2'd0: begin op_a = wmag[MAG_W-1:HALF_W]; op_b = wmag[MAG_W-1:HALF_W]; end
      2'd1: begin op_a = wmag[MAG_W-1:HALF_W]; op_b = wmag[HALF_W-1:0]; end
      default: begin op_a = wmag[HALF_W-1:0]; op_b = wmag[HALF_W-1:0]; end
    endcase
    pp = op_a * op_b;
    case (j)
      2'd0: pp_sh = SUM_W'(pp) << (2 * HALF_W);
      2'd1: pp_sh = SUM_W'(pp) << (HALF_W + 1);
      default: pp_sh = SUM_W'(pp);
    endcase
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    we         = 1'b0;
    raddr      = head.addr;
    sq_start   = 1'b0;
    out_load   = 1'b0;
    case (state)
      B_IDLE: begin
        if (qs.valid) begin
          pop = 1'b1;
          if (head.action == ACT_LOAD) we = 1'b1;
          else state_next = B_RDB;
        end
      end
      B_RDB: begin
        raddr      = qb;
        state_next = B_RDC;
      end
      B_RDC: begin
        raddr      = qc;
        state_next = B_CAPC;
      end
      B_CAPC: state_next = B_EDGE;
      B_EDGE: state_next = B_MUL;
      B_MUL:  state_next = B_DIFF;
      B_DIFF: state_next = B_SQ;
      B_SQ: begin
        if (j == 2'd2) begin
          if (k == 2'd2) begin
            sq_start   = 1'b1;
            state_next = B_ROOT;
          end else begin
            state_next = B_MUL;
          end
        end
      end
      B_ROOT: if (sq.done) state_next = B_DONE;
      B_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      k         <= '0;
      j         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_EDGE) begin
        k <= '0;
        j <= '0;
      end else if (state == B_SQ) begin
        j <= (j == 2'd2) ? 2'd0 : j + 1'b1;
        if (j == 2'd2) k <= k + 1'b1;
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        qb <= head.b;
        qc <= head.c;
      end
      B_RDB:  va <= rd_data;
      B_RDC:  vb <= rd_data;
      B_CAPC: vc <= rd_data;
      B_EDGE: begin
        ux  <= {va[47], va[47:32]} - {vb[47], vb[47:32]};
        uy  <= {va[31], va[31:16]} - {vb[31], vb[31:16]};
        uz  <= {va[15], va[15:0]}  - {vb[15], vb[15:0]};
        vx  <= {va[47], va[47:32]} - {vc[47], vc[47:32]};
        vy  <= {va[31], va[31:16]} - {vc[31], vc[31:16]};
        vz  <= {va[15], va[15:0]}  - {vc[15], vc[15:0]};
        acc <= '0;
      end
      B_MUL: begin
        p1 <= m1a * m1b;
        p2 <= m2a * m2b;
      end
      B_DIFF: wmag <= d[PROD_W] ? MAG_W'(-d) : MAG_W'(d);
      B_SQ:   acc <= acc + pp_sh;
      B_DONE: if (out_load) tri_area <= sq.root[ROOT_W-1:1];
      default: ;
    endcase
  end

endmodule

[src/indexed_triangle_area.sv]
// Indexed triangle area: vertex store with per-query cross-product area.
// Load beats (action 0) write one vertex; query beats (action 1) give one area.
// Input channel in_valid/in_stall; result channel out_valid/out_stall.
// A four-entry command queue sits between the front and the back end, so the
// input keeps accepting beats while the back end works or the receiver stalls.
// The back end runs one command at a time, in arrival order:
//   load:  one memory write.
//   query: the pop, three corner reads on the single memory read port,
//          edge vectors, then per cross component a product step, a
//          difference step and three 18x18 partial squares, then the
//          bit-serial square root, then the output register.
// A held result stalls only the back end; the queue keeps filling until
// full, then in_stall rises. tri_area holds while stalled.
// Synchronous reset empties the queue and clears out_valid. The vertex memory
// is not cleared: query only corners that have been loaded.
module indexed_triangle_area import ita_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [IDX_W-1:0]          vertex_index,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic [IDX_W-1:0]          corner_a,
  input  logic [IDX_W-1:0]          corner_b,
  input  logic [IDX_W-1:0]          corner_c,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [AREA_W-1:0]         tri_area
);

  cmd_t    head;
  q_stat_t qs;
  logic    pop;

  ita_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .vertex_index (vertex_index),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .coord_z      (coord_z),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .pop          (pop),
    .head         (head),
    .stat         (qs)
  );

  ita_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qs        (qs),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tri_area  (tri_area)
  );

  a_qcount: assert property (@(posedge clk) disable iff (rst)
    qs.count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qs.valid)
    else $error("pop from empty queue");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

[verif/indexed_triangle_area_checker.sv]
// Checker for the indexed triangle area block: watches both channels, keeps
// its own vertex table, predicts each query's area and compares in order.
// Depends on ita_pkg; hands a failure count to the testbench top.
module indexed_triangle_area_checker import ita_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      action,
  input  logic [IDX_W-1:0]          vertex_index,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic [IDX_W-1:0]          corner_a,
  input  logic [IDX_W-1:0]          corner_b,
  input  logic [IDX_W-1:0]          corner_c,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [AREA_W-1:0]         tri_area,
  output int                        fail_count,
  output int                        pending_areas
);

  logic signed [COORD_W-1:0] vx_mem [VERTEX_COUNT];
  logic signed [COORD_W-1:0] vy_mem [VERTEX_COUNT];
  logic signed [COORD_W-1:0] vz_mem [VERTEX_COUNT];
  logic [AREA_W-1:0] area_queue [$];

  function automatic logic [AREA_W-1:0] triangle_area(input logic [IDX_W-1:0] ia,
                                                      input logic [IDX_W-1:0] ib,
                                                      input logic [IDX_W-1:0] ic);
    longint ux, uy, uz, vx, vy, vz, wx, wy, wz;
    logic [71:0] sum, trial;
    logic [35:0] root, cand;
    ux = longint'(vx_mem[ia]) - vx_mem[ib];
    uy = longint'(vy_mem[ia]) - vy_mem[ib];
    uz = longint'(vz_mem[ia]) - vz_mem[ib];
    vx = longint'(vx_mem[ia]) - vx_mem[ic];
    vy = longint'(vy_mem[ia]) - vy_mem[ic];
    vz = longint'(vz_mem[ia]) - vz_mem[ic];
    wx = uy * vz - uz * vy;
    wy = uz * vx - ux * vz;
    wz = ux * vy - uy * vx;
    if (wx < 0) wx = -wx;
    if (wy < 0) wy = -wy;
    if (wz < 0) wz = -wz;
    sum = 72'(wx) * 72'(wx) + 72'(wy) * 72'(wy) + 72'(wz) * 72'(wz);
    root = '0;
    for (int bitpos = 35; bitpos >= 0; bitpos--) begin
      cand = root | (36'd1 << bitpos);
      trial = 72'(cand) * 72'(cand);
      if (trial <= sum) root = cand;
    end
    return AREA_W'(root >> 1);
  endfunction

  assign pending_areas = area_queue.size();

  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
      area_queue.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (action_t'(action) == ACT_LOAD) begin
          vx_mem[vertex_index] = coord_x;
          vy_mem[vertex_index] = coord_y;
          vz_mem[vertex_index] = coord_z;
        end else begin
          area_queue = {area_queue, triangle_area(corner_a, corner_b, corner_c)};
        end
      end
      if (out_valid && !out_stall) begin
        if (area_queue.size() == 0) begin
          $display("%0t: unexpected area beat, expected none, actual %0d", $time, tri_area);
          fail_count <= fail_count + 1;
        end else begin
          if (area_queue[0] !== tri_area) begin
            $display("%0t: tri_area mismatch, expected %0d, actual %0d", $time,
                     area_queue[0], tri_area);
            fail_count <= fail_count + 1;
          end
          void'(area_queue.pop_front());
        end
      end
    end
  end

endmodule

[verif/indexed_triangle_area_tb.sv]
// Testbench top for the indexed triangle area block: loads vertices, sends
// directed and random area queries with random idling, and gives the verdict.
// Depends on ita_pkg, indexed_triangle_area and indexed_triangle_area_checker.
module indexed_triangle_area_tb;
  import ita_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [IDX_W-1:0] vertex_index = '0;
  logic signed [COORD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [IDX_W-1:0] corner_a = '0, corner_b = '0, corner_c = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [AREA_W-1:0] tri_area;
  int fail_count, pending_areas;
  int idle_cycles = 0;
  int out_gap = 0;
  bit out_taken = 1'b0;
  bit loaded [VERTEX_COUNT];
  int loaded_list [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  indexed_triangle_area uut (.*);
  indexed_triangle_area_checker checker_i (.*);

  task automatic send_beat(input action_t act, input int idx, input int xv, input int yv,
                           input int zv, input int ca, input int cb, input int cc);
    int gap;
    gap = $urandom_range(0, 5);
    repeat (gap) @(negedge clk);
    in_valid <= 1'b1;
    action <= act;
    vertex_index <= IDX_W'(idx);
    coord_x <= COORD_W'(xv); coord_y <= COORD_W'(yv); coord_z <= COORD_W'(zv);
    corner_a <= IDX_W'(ca); corner_b <= IDX_W'(cb); corner_c <= IDX_W'(cc);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    if (act == ACT_LOAD && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list = {loaded_list, idx};
    end
  endtask

  task automatic load_vertex(input int idx, input int xv, input int yv, input int zv);
    send_beat(ACT_LOAD, idx, xv, yv, zv, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023));
  endtask

  task automatic query_area(input int ca, input int cb, input int cc);
    send_beat(ACT_QUERY, $urandom_range(0, 1023), $urandom, $urandom, $urandom, ca, cb, cc);
  endtask

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 64)) - 32;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  always @(posedge clk) begin
    out_taken <= out_valid && !out_stall;
  end

  always @(negedge clk) begin
    if (out_taken) out_gap = $urandom_range(0, 5);
    if (out_gap > 0 && out_valid) begin
      out_stall <= 1'b1;
      out_gap = out_gap - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    load_vertex(0, 32767, 32767, 32767);
    load_vertex(1, -32768, -32768, -32768);
    load_vertex(2, 32767, -32768, 0);
    load_vertex(1023, -32768, 32767, 32767);
    load_vertex(3, 256, 0, 0);
    load_vertex(4, 0, 256, 0);
    load_vertex(5, 512, 0, 0);
    load_vertex(6, 0, 0, 0);
    load_vertex(7, 21845, -10923, 5461);
    query_area(1, 2, 1023);
    query_area(0, 1, 2);
    query_area(6, 3, 4);
    query_area(6, 3, 5);
    query_area(6, 6, 6);
    query_area(3, 3, 4);
    query_area(1023, 0, 1);
    query_area(7, 1, 2);
    query_area(2, 1023, 0);
    for (int n = 0; n < 800; n++) begin
      if (loaded_list.size() < 3 || $urandom_range(0, 2) == 0)
        load_vertex($urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
      else
        query_area(pick_loaded(), pick_loaded(), pick_loaded());
    end
    while (pending_areas != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
